FILE: sv/g3sf_pkg.sv
// ----------------------------------------------------------------------------
// g3sf_pkg
// Shared constants and types for the 3x3 smoothing filter.
// ----------------------------------------------------------------------------
package g3sf_pkg;

  localparam int PIX_W     = 8;
  localparam int MAX_WIDTH = 2048;
  localparam int MIN_WIDTH = 4;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int LW_W      = 12;
  localparam int WGT_W     = 8;
  localparam int ROW_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 12;
  // wide enough for both the raw register and the clamp limit
  localparam int CMP_W     = (LW_W > COL_W + 1) ? LW_W : COL_W + 1;
  localparam int SUM4_W    = PIX_W + 2;
  localparam int PROD_W    = SUM4_W + WGT_W;
  localparam int ACC_W     = PROD_W + 2;

  localparam logic [LW_W-1:0]  LINE_WIDTH_RST    = LW_W'(640);
  localparam logic [WGT_W-1:0] CENTER_WEIGHT_RST = WGT_W'(38);
  localparam logic [WGT_W-1:0] EDGE_WEIGHT_RST   = WGT_W'(31);
  localparam logic [WGT_W-1:0] CORNER_WEIGHT_RST = WGT_W'(23);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINE_WIDTH    = 2'd0,
    CFG_CENTER_WEIGHT = 2'd1,
    CFG_EDGE_WEIGHT   = 2'd2,
    CFG_CORNER_WEIGHT = 2'd3
  } cfg_idx_t;

endpackage

FILE: sv/g3sf_ram.sv
// ----------------------------------------------------------------------------
// g3sf_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module g3sf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/gaussian_3x3_smoothing_filter.sv
// ----------------------------------------------------------------------------
// gaussian_3x3_smoothing_filter
// Line-buffered 3x3 weighted smoothing of a raster-order gray pixel stream.
// ----------------------------------------------------------------------------
// Path: an accepted pixel passes the input stage, then the result register.
// Throughput: one pixel per cycle while the output is not stalled; the line buffer
//   read at acceptance and its write-back when the pixel leaves the input stage overlap, with a bypass.
// Reset (rst_n low, synchronous): counters, window and valid flags cleared,
//   registers back to their defaults; line buffers are not cleared.
module gaussian_3x3_smoothing_filter (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration write port
  input  logic                             cfg_we,
  input  logic [g3sf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [g3sf_pkg::CFG_DAT_W-1:0]   cfg_wdata,
  // input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,   // [7:0] pixel
  input  logic [0:0]                       in_tuser,   // [0] frame_start
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [7:0]                       out_tdata,  // [7:0] smoothed
  output logic [0:0]                       out_tuser,  // [0] center_valid
  output logic                             out_tlast   // end_of_row
);

  localparam int PIX_W  = g3sf_pkg::PIX_W;
  localparam int COL_W  = g3sf_pkg::COL_W;
  localparam int CMP_W  = g3sf_pkg::CMP_W;
  localparam int ROW_W  = g3sf_pkg::ROW_W;
  localparam int SUM4_W = g3sf_pkg::SUM4_W;
  localparam int PROD_W = g3sf_pkg::PROD_W;
  localparam int ACC_W  = g3sf_pkg::ACC_W;

  // configuration registers
  logic [g3sf_pkg::LW_W-1:0]  line_width_r;
  logic [g3sf_pkg::WGT_W-1:0] center_weight_r;
  logic [g3sf_pkg::WGT_W-1:0] edge_weight_r;
  logic [g3sf_pkg::WGT_W-1:0] corner_weight_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r    <= g3sf_pkg::LINE_WIDTH_RST;
      center_weight_r <= g3sf_pkg::CENTER_WEIGHT_RST;
      edge_weight_r   <= g3sf_pkg::EDGE_WEIGHT_RST;
      corner_weight_r <= g3sf_pkg::CORNER_WEIGHT_RST;
    end else if (cfg_we) begin
      unique case (g3sf_pkg::cfg_idx_t'(cfg_index))
        g3sf_pkg::CFG_LINE_WIDTH:    line_width_r    <= cfg_wdata[g3sf_pkg::LW_W-1:0];
        g3sf_pkg::CFG_CENTER_WEIGHT: center_weight_r <= cfg_wdata[g3sf_pkg::WGT_W-1:0];
        g3sf_pkg::CFG_EDGE_WEIGHT:   edge_weight_r   <= cfg_wdata[g3sf_pkg::WGT_W-1:0];
        g3sf_pkg::CFG_CORNER_WEIGHT: corner_weight_r <= cfg_wdata[g3sf_pkg::WGT_W-1:0];
        default: ;
      endcase
    end
  end

  // effective row width, clamped into the supported range
  logic [CMP_W-1:0] lw_ext;
  logic [CMP_W-1:0] eff_w;
  always_comb begin
    lw_ext = CMP_W'(line_width_r);
    if (lw_ext < CMP_W'(g3sf_pkg::MIN_WIDTH)) begin
      eff_w = CMP_W'(g3sf_pkg::MIN_WIDTH);
    end else if (lw_ext > CMP_W'(g3sf_pkg::MAX_WIDTH)) begin
      eff_w = CMP_W'(g3sf_pkg::MAX_WIDTH);
    end else begin
      eff_w = lw_ext;
    end
  end

  // handshakes
  logic s1_valid_r;
  logic out_valid_r;
  logic s1_adv;
  logic acc;

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign acc       = in_tvalid && in_tready;

  // position of the incoming pixel
  logic [COL_W-1:0] column_count_r, column_count_nxt;
  logic [ROW_W-1:0] row_count_r, row_count_nxt;
  logic [COL_W-1:0] col_raw;
  logic [COL_W-1:0] col_cur;
  logic [ROW_W-1:0] row_cur;
  logic [CMP_W-1:0] w_last;
  logic             last_cur;
  logic             valid_cur;

  always_comb begin
    w_last  = eff_w - CMP_W'(1);
    col_raw = in_tuser[0] ? '0 : column_count_r;
    row_cur = in_tuser[0] ? '0 : row_count_r;
    // a column past the row end is taken as the last one
    if (CMP_W'(col_raw) >= eff_w) begin
      col_cur = w_last[COL_W-1:0];
    end else begin
      col_cur = col_raw;
    end
    last_cur  = (CMP_W'(col_cur) == w_last);
    valid_cur = (row_cur >= ROW_W'(2)) && (col_cur >= COL_W'(3));
    if (last_cur) begin
      column_count_nxt = '0;
      row_count_nxt    = (row_cur == '1) ? row_cur : row_cur + ROW_W'(1);
    end else begin
      column_count_nxt = col_cur + COL_W'(1);
      row_count_nxt    = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_count_r <= '0;
      row_count_r    <= '0;
    end else if (acc) begin
      column_count_r <= column_count_nxt;
      row_count_r    <= row_count_nxt;
    end
  end

  // input stage
  logic [PIX_W-1:0] s1_px_r;
  logic [COL_W-1:0] s1_col_r;
  logic             s1_last_r;
  logic             s1_cv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_px_r   <= in_tdata[PIX_W-1:0];
      s1_col_r  <= col_cur;
      s1_last_r <= last_cur;
      s1_cv_r   <= valid_cur;
    end
  end

  // line buffers: read at acceptance, write back as the pixel leaves stage 1
  logic [PIX_W-1:0] up_dout, mid_dout;
  logic [PIX_W-1:0] up_rd, mid_rd;
  logic             byp_hit_r;
  logic [PIX_W-1:0] byp_up_r, byp_mid_r;

  g3sf_ram #(.WIDTH(PIX_W), .DEPTH(g3sf_pkg::MAX_WIDTH)) u_upper_line (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col_r),
    .wdata (mid_rd),
    .re    (acc),
    .raddr (col_cur),
    .rdata (up_dout)
  );

  g3sf_ram #(.WIDTH(PIX_W), .DEPTH(g3sf_pkg::MAX_WIDTH)) u_middle_line (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col_r),
    .wdata (s1_px_r),
    .re    (acc),
    .raddr (col_cur),
    .rdata (mid_dout)
  );

  // forward a write that lands on the address read in the same cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_hit_r <= 1'b0;
    end else if (acc) begin
      byp_hit_r <= s1_adv && (s1_col_r == col_cur);
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      byp_up_r  <= mid_rd;
      byp_mid_r <= s1_px_r;
    end
  end

  assign up_rd  = byp_hit_r ? byp_up_r  : up_dout;
  assign mid_rd = byp_hit_r ? byp_mid_r : mid_dout;

  // 3x3 window, index = row * 3 + column, newest column on the right
  logic [PIX_W-1:0] win_r   [9];
  logic [PIX_W-1:0] win_nxt [9];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_nxt[r*3]   = win_r[r*3+1];
      win_nxt[r*3+1] = win_r[r*3+2];
    end
    win_nxt[2] = up_rd;
    win_nxt[5] = mid_rd;
    win_nxt[8] = s1_px_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= '0;
      end
    end else if (s1_adv) begin
      win_r <= win_nxt;
    end
  end

  // weighted sum, one truncation, saturate; zero for an invalid centre
  logic [SUM4_W-1:0] edges, corners;
  logic [PROD_W-1:0] p_center, p_edge, p_corner;
  logic [ACC_W-1:0]  sum;
  logic [PIX_W-1:0]  res;

  always_comb begin
    edges    = SUM4_W'(win_nxt[1]) + SUM4_W'(win_nxt[3])
             + SUM4_W'(win_nxt[5]) + SUM4_W'(win_nxt[7]);
    corners  = SUM4_W'(win_nxt[0]) + SUM4_W'(win_nxt[2])
             + SUM4_W'(win_nxt[6]) + SUM4_W'(win_nxt[8]);
    p_center = PROD_W'(win_nxt[4]) * PROD_W'(center_weight_r);
    p_edge   = PROD_W'(edges) * PROD_W'(edge_weight_r);
    p_corner = PROD_W'(corners) * PROD_W'(corner_weight_r);
    sum      = ACC_W'(p_center) + ACC_W'(p_edge) + ACC_W'(p_corner);
    if (!s1_cv_r) begin
      res = '0;
    end else if (sum[ACC_W-1:8] > (ACC_W-8)'(255)) begin
      res = '1;
    end else begin
      res = sum[15:8];
    end
  end

  // result register
  logic [PIX_W-1:0] out_px_r;
  logic             out_cv_r;
  logic             out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_px_r   <= res;
      out_cv_r   <= s1_cv_r;
      out_last_r <= s1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_px_r;
  assign out_tuser  = out_cv_r;
  assign out_tlast  = out_last_r;

  // checks
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_cv_r |-> out_px_r == '0)
    else $error("invalid centre carries a non-zero result");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> s1_valid_r)
    else $error("accepted request lost from the input stage");

  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("advanced request lost from the result register");

  a_frame_col0: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_tuser[0] |=> s1_col_r == '0)
    else $error("frame start not taken as column zero");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_col_r))
    else $error("stalled input stage changed");

endmodule
